// File: sv/ddo_pkg.sv
// Shared types, constants and a helper function for the differential drive odometry block.
package ddo_pkg;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic        [15:0] elapsed_ms;
    } meas_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic        [15:0] heading;
        logic signed [31:0] left_travel;
        logic signed [31:0] right_travel;
    } pose_t;

    localparam logic CFG_WHEEL_RADIUS = 1'b0;
    localparam logic CFG_WHEEL_BASE   = 1'b1;

    localparam logic [15:0] RADIUS_RESET = 16'd768;
    localparam logic [15:0] BASE_RESET   = 16'd4096;
    localparam logic signed [31:0] POS_RESET = 32'sd983040;

    localparam logic [31:0] ARC_K  = 32'd26986075;
    localparam logic [31:0] HEAD_C = 32'd2670177;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam int ATAN_LEN = 24;
    localparam int DIV_W    = 49;
    localparam int ARC_W    = 42;
    localparam int CS_W     = 34;

    localparam logic [29:0] ATAN_TAB [ATAN_LEN] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
        30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
        30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051
    };

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] r;
        if (v > 43'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -43'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/ddo_mul.sv
// Shared unsigned 32 by 32 multiplier with a registered product.
module ddo_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);
    logic [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= {32'b0, a} * {32'b0, b};
    end

    assign prod = prod_reg;
endmodule

// File: sv/ddo_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ddo_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ddo_pkg::DIV_W-1:0] dividend,
    input  logic [15:0]               divisor,
    output logic                      done,
    output logic [15:0]               quotient
);
    import ddo_pkg::*;

    logic [DIV_W-1:0] work_reg;
    logic [15:0]      rem_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [16:0]      trial;
    logic [16:0]      diff;
    logic             qbit;

    assign trial = {rem_reg, work_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign qbit  = !diff[16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[DIV_W-2:0], qbit};
            rem_reg  <= qbit ? diff[15:0] : trial[15:0];
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg[15:0];
endmodule

// File: sv/ddo_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
module ddo_cordic #(
    parameter int STEPS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [15:0]                     angle,
    output logic                            busy,
    output logic signed [ddo_pkg::CS_W-1:0] cos_out,
    output logic signed [ddo_pkg::CS_W-1:0] sin_out
);
    import ddo_pkg::*;

    localparam int N = (STEPS < ATAN_LEN) ? STEPS : ATAN_LEN;

    logic signed [CS_W-1:0] x_reg;
    logic signed [CS_W-1:0] y_reg;
    logic signed [CS_W-1:0] z_reg;
    logic [4:0]             i_reg;
    logic                   busy_reg;
    logic                   flip_reg;
    logic                   flip;
    logic [15:0]            folded;
    logic signed [CS_W-1:0] tx;
    logic signed [CS_W-1:0] ty;
    logic signed [CS_W-1:0] at;

    assign flip   = (angle >= 16'd16384) && (angle < 16'd49152);
    assign folded = flip ? angle + 16'd32768 : angle;
    assign tx     = y_reg >>> i_reg;
    assign ty     = x_reg >>> i_reg;
    assign at     = $signed({4'b0, ATAN_TAB[i_reg]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            i_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (i_reg == 5'(N - 1))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                i_reg <= i_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({{2{folded[15]}}, folded, 16'b0});
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[CS_W-1])
            begin
                x_reg <= x_reg - tx;
                y_reg <= y_reg + ty;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + tx;
                y_reg <= y_reg - ty;
                z_reg <= z_reg + at;
            end
        end
    end

    assign busy    = busy_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
endmodule

// File: sv/differential_drive_odometry.sv
// Differential drive odometry: sequencer, pose state and output register.
// One measurement beat is taken when the block is idle, and the next measurement can be taken
// as soon as the new pose appears. The sequencer forms the two wheel arcs on the shared
// multiplier (ARC0 to ARC4, once per wheel) while the CORDIC, 16 steps by default, runs
// alongside, then waits in MEAN for the CORDIC to finish. It then forms the two displacements
// (DSP0 to DSP2, once per axis) and the heading product (HD0 to HD2), and waits in DIVW for
// the serial heading divider and its done flag. FIN loads the output register and the
// sequencer goes back to idle. The result beat waits in an output register, so a new
// measurement can start while the previous pose has not yet been taken. An untaken pose holds
// the sequencer in its last step until it is taken.
module differential_drive_odometry #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           meas_valid,
    output logic           meas_ready,
    input  ddo_pkg::meas_t meas,
    output logic           pose_valid,
    input  logic           pose_ready,
    output ddo_pkg::pose_t pose,
    input  logic           cfg_we,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data
);
    import ddo_pkg::*;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ARC0 = 4'd1;
    localparam logic [3:0] ST_ARC1 = 4'd2;
    localparam logic [3:0] ST_ARC2 = 4'd3;
    localparam logic [3:0] ST_ARC3 = 4'd4;
    localparam logic [3:0] ST_ARC4 = 4'd5;
    localparam logic [3:0] ST_MEAN = 4'd6;
    localparam logic [3:0] ST_DSP0 = 4'd7;
    localparam logic [3:0] ST_DSP1 = 4'd8;
    localparam logic [3:0] ST_DSP2 = 4'd9;
    localparam logic [3:0] ST_HD0  = 4'd10;
    localparam logic [3:0] ST_HD1  = 4'd11;
    localparam logic [3:0] ST_HD2  = 4'd12;
    localparam logic [3:0] ST_DIVW = 4'd13;
    localparam logic [3:0] ST_FIN  = 4'd14;

    logic [3:0]  state_reg;
    logic [15:0] radius_reg;
    logic [15:0] base_reg;
    meas_t       meas_reg;

    logic signed [31:0] x_reg;
    logic signed [31:0] y_reg;
    logic [15:0]        heading_reg;
    logic signed [31:0] lt_reg;
    logic signed [31:0] rt_reg;

    logic                    side_reg;
    logic                    axis_reg;
    logic [47:0]             p_reg;
    logic [63:0]             lo_reg;
    logic signed [ARC_W-1:0] dl_reg;
    logic signed [ARC_W-1:0] dr_reg;
    logic [40:0]             dd_mag_reg;
    logic                    dd_neg_reg;
    logic [41:0]             dmag_reg;
    logic                    dneg_reg;

    pose_t pose_reg;
    logic  pose_valid_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    logic                   cordic_start;
    logic                   cordic_busy;
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;

    logic             div_start;
    logic             div_done;
    logic [15:0]      div_q;
    logic [DIV_W-1:0] div_dividend;
    logic [15:0]      base_eff;

    logic signed [15:0]      speed_s;
    logic [15:0]             speed_mag;
    logic [73:0]             arc_full;
    logic signed [ARC_W-1:0] arc_s;
    logic signed [42:0]      arc_sum;
    logic signed [42:0]      arc_half;
    logic signed [42:0]      arc_diff;
    logic signed [42:0]      arc_diff_abs;
    logic signed [CS_W-1:0]  c_sel;
    logic [31:0]             c_abs;
    logic [71:0]             dsp_full;
    logic [41:0]             dsp_mag;
    logic signed [42:0]      dsp_s;
    logic signed [42:0]      pos_sum;
    logic [65:0]             hd_num;
    logic [65:0]             hd_rnd;
    logic                    accept;

    assign accept     = meas_valid && meas_ready;
    assign meas_ready = (state_reg == ST_IDLE);
    assign base_eff   = (base_reg == 16'd0) ? 16'd1 : base_reg;

    assign speed_s   = side_reg ? meas_reg.right_speed : meas_reg.left_speed;
    assign speed_mag = speed_s[15] ? 16'(-speed_s) : speed_s;
    assign arc_full  = {prod[49:0], 24'b0} + {10'b0, lo_reg} + 74'h80000000;
    assign arc_s     = speed_s[15] ? -$signed({1'b0, arc_full[72:32]})
                                   : $signed({1'b0, arc_full[72:32]});

    assign arc_sum      = {dl_reg[ARC_W-1], dl_reg} + {dr_reg[ARC_W-1], dr_reg};
    assign arc_half     = arc_sum[42] ? (arc_sum + 43'sd1) >>> 1 : arc_sum >>> 1;
    assign arc_diff     = {dr_reg[ARC_W-1], dr_reg} - {dl_reg[ARC_W-1], dl_reg};
    assign arc_diff_abs = arc_diff[42] ? -arc_diff : arc_diff;

    assign c_sel    = axis_reg ? sin_v : cos_v;
    assign c_abs    = c_sel[CS_W-1] ? 32'(-c_sel) : c_sel[31:0];
    assign dsp_full = {prod[47:0], 24'b0} + {8'b0, lo_reg} + 72'h20000000;
    assign dsp_mag  = dsp_full[71:30];
    assign dsp_s    = (dd_neg_reg ^ c_sel[CS_W-1]) ? -$signed({1'b0, dsp_mag})
                                                  : $signed({1'b0, dsp_mag});
    assign pos_sum  = (axis_reg ? {{11{y_reg[31]}}, y_reg} : {{11{x_reg[31]}}, x_reg}) + dsp_s;

    assign hd_num       = {prod[41:0], 24'b0} + {2'b0, lo_reg};
    assign hd_rnd       = hd_num + {35'b0, base_eff, 15'b0};
    assign div_dividend = hd_rnd[DIV_W+15:16];

    assign cordic_start = accept;
    assign div_start    = (state_reg == ST_HD2);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_ARC0:
            begin
                mul_a = {16'b0, speed_mag};
                mul_b = {16'b0, meas_reg.elapsed_ms};
            end
            ST_ARC1:
            begin
                mul_a = prod[31:0];
                mul_b = {16'b0, radius_reg};
            end
            ST_ARC2:
            begin
                mul_a = {8'b0, prod[23:0]};
                mul_b = ARC_K;
            end
            ST_ARC3:
            begin
                mul_a = {8'b0, p_reg[47:24]};
                mul_b = ARC_K;
            end
            ST_DSP0:
            begin
                mul_a = {8'b0, dd_mag_reg[23:0]};
                mul_b = c_abs;
            end
            ST_DSP1:
            begin
                mul_a = {15'b0, dd_mag_reg[40:24]};
                mul_b = c_abs;
            end
            ST_HD0:
            begin
                mul_a = {8'b0, dmag_reg[23:0]};
                mul_b = HEAD_C;
            end
            ST_HD1:
            begin
                mul_a = {14'b0, dmag_reg[41:24]};
                mul_b = HEAD_C;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    ddo_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .angle   (heading_reg),
        .busy    (cordic_busy),
        .cos_out (cos_v),
        .sin_out (sin_v)
    );

    ddo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (base_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            radius_reg     <= RADIUS_RESET;
            base_reg       <= BASE_RESET;
            x_reg          <= POS_RESET;
            y_reg          <= POS_RESET;
            heading_reg    <= '0;
            lt_reg         <= '0;
            rt_reg         <= '0;
            side_reg       <= 1'b0;
            axis_reg       <= 1'b0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WHEEL_RADIUS)
                begin
                    radius_reg <= cfg_data;
                end
                else
                begin
                    base_reg <= cfg_data;
                end
            end

            if (pose_valid_reg && pose_ready && state_reg != ST_FIN)
            begin
                pose_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        side_reg  <= 1'b0;
                        state_reg <= ST_ARC0;
                    end
                end
                ST_ARC0: state_reg <= ST_ARC1;
                ST_ARC1: state_reg <= ST_ARC2;
                ST_ARC2: state_reg <= ST_ARC3;
                ST_ARC3: state_reg <= ST_ARC4;
                ST_ARC4:
                begin
                    side_reg  <= !side_reg;
                    state_reg <= side_reg ? ST_MEAN : ST_ARC0;
                end
                ST_MEAN:
                begin
                    if (!cordic_busy)
                    begin
                        lt_reg    <= sat32({dl_reg[ARC_W-1], dl_reg} + {{11{lt_reg[31]}}, lt_reg});
                        rt_reg    <= sat32({dr_reg[ARC_W-1], dr_reg} + {{11{rt_reg[31]}}, rt_reg});
                        axis_reg  <= 1'b0;
                        state_reg <= ST_DSP0;
                    end
                end
                ST_DSP0: state_reg <= ST_DSP1;
                ST_DSP1: state_reg <= ST_DSP2;
                ST_DSP2:
                begin
                    if (axis_reg)
                    begin
                        y_reg     <= sat32(pos_sum);
                        state_reg <= ST_HD0;
                    end
                    else
                    begin
                        x_reg     <= sat32(pos_sum);
                        state_reg <= ST_DSP0;
                    end
                    axis_reg <= !axis_reg;
                end
                ST_HD0: state_reg <= ST_HD1;
                ST_HD1: state_reg <= ST_HD2;
                ST_HD2: state_reg <= ST_DIVW;
                ST_DIVW:
                begin
                    if (div_done)
                    begin
                        heading_reg <= dneg_reg ? heading_reg - div_q : heading_reg + div_q;
                        state_reg   <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!pose_valid_reg || pose_ready)
                    begin
                        pose_valid_reg <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meas_reg <= meas;
        end
        if (state_reg == ST_ARC2)
        begin
            p_reg <= prod[47:0];
        end
        if (state_reg == ST_ARC3 || state_reg == ST_DSP1 || state_reg == ST_HD1)
        begin
            lo_reg <= prod;
        end
        if (state_reg == ST_ARC4)
        begin
            if (side_reg)
            begin
                dr_reg <= arc_s;
            end
            else
            begin
                dl_reg <= arc_s;
            end
        end
        if (state_reg == ST_MEAN)
        begin
            dd_neg_reg <= arc_half[42];
            dd_mag_reg <= arc_half[42] ? 41'(-arc_half) : arc_half[40:0];
            dneg_reg   <= arc_diff[42];
            dmag_reg   <= arc_diff_abs[41:0];
        end
        if (state_reg == ST_FIN && (!pose_valid_reg || pose_ready))
        begin
            pose_reg.pos_x        <= x_reg;
            pose_reg.pos_y        <= y_reg;
            pose_reg.heading      <= heading_reg;
            pose_reg.left_travel  <= lt_reg;
            pose_reg.right_travel <= rt_reg;
        end
    end

    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIVW)
        else $error("Divider finished outside its wait state.");

    a_cordic_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !cordic_busy)
        else $error("CORDIC still busy while the sequencer is idle.");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> cordic_busy && state_reg == ST_ARC0)
        else $error("Accepted beat did not start the sequence.");
endmodule
